FILE: sv/srb_pkg.sv
// Shared constants and types for the sequence reorder buffer.
`default_nettype none

package srb_pkg;

  localparam int WINDOW_DEF = 32;
  localparam int SEQ_W      = 30;
  localparam int RAW_W      = 32;
  localparam int TAG_W      = 32;
  localparam int STATUS_W   = 4;

  typedef enum logic [STATUS_W-1:0] {
    ST_DELIVERED     = 4'd0,
    ST_PARKED        = 4'd1,
    ST_RESEND_PARKED = 4'd2,
    ST_BAD_PARITY    = 4'd3,
    ST_AHEAD_LOCAL   = 4'd4,
    ST_STALE         = 4'd5,
    ST_MIXED         = 4'd6,
    ST_OVERFLOW      = 4'd7,
    ST_NO_MESSAGE    = 4'd8
  } status_t;

  // One window slot as held in memory.
  typedef struct packed {
    logic             valid;
    logic             payload;
    logic [TAG_W-1:0] tag;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

`default_nettype wire

FILE: sv/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer: checks, window store and delivery sequencer.
//
// Receive-side reorder buffer. One transaction is processed at a time; in_stall is high
// while an item is in flight. A dropped, rejected or pass-through item is evaluated and
// then reported; a parked item first reads its window slot and then writes it only if
// the slot is empty. An in-order item with a run of parked successors first counts the
// run by reading the window memory one slot per cycle, then reads it again and delivers
// one transaction per cycle while the output is not stalled, each slot cleared as it
// leaves. The window memory has a single read port, so the run is read twice; output
// stalls hold the delivery.
// After reset a clearing pass empties every window slot before the first item
// is taken; configuration writes are taken at any time.
`default_nettype none

module sequence_reorder_buffer
  import srb_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_wdata,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [RAW_W-1:0] in_raw_in_seq,
  input  wire logic signed [RAW_W-1:0] in_raw_out_seq,
  input  wire logic        [TAG_W-1:0] in_message_tag,
  input  wire logic                    in_message_ok,
  input  wire logic                    in_is_resend_request,
  input  wire logic        [SEQ_W-1:0] in_local_out_seq,
  // result channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic          [STATUS_W-1:0] out_status,
  output logic             [TAG_W-1:0] out_tag,
  output logic                         out_has_payload,
  output logic             [SEQ_W-1:0] out_seq,
  output logic             [SEQ_W-1:0] out_expected_after,
  output logic                         out_last
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_EVAL, S_PARK, S_OUT, S_SCAN, S_HEAD, S_DRAIN
  } state_t;

  typedef enum logic [1:0] {K_REPORT, K_PARK, K_INORDER} kind_t;

  // Physical slot of window distance d, given the head slot.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] d);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(d);
    if (s >= SW'(WINDOW)) begin
      s = s - SW'(WINDOW);
    end
    return s[AW-1:0];
  endfunction

  state_t            state_r;
  logic              admin_r;
  logic [SEQ_W-1:0]  expected_r;
  logic [AW-1:0]     head_r;
  logic [CW-1:0]     d_r;
  logic [CW-1:0]     n_r;
  logic [SEQ_W-1:0]  exp_after_r;
  logic [AW-1:0]     park_addr_r;

  // captured transaction
  logic [RAW_W-1:0]  rin_r;
  logic [RAW_W-1:0]  rout_r;
  logic [TAG_W-1:0]  tag_in_r;
  logic              ok_r;
  logic              resend_r;
  logic [SEQ_W-1:0]  local_r;

  // single-result holding registers
  status_t           res_status_r;
  logic [TAG_W-1:0]  res_tag_r;
  logic              res_pay_r;
  logic [SEQ_W-1:0]  res_seq_r;

  // output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic              out_pay_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic [SEQ_W-1:0]  out_exp_r;
  logic              out_last_r;

  // memory port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  slot_t             ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  slot_t             rd;

  srb_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd)
  );

  // ---------------- evaluation of the captured item ----------------
  logic              in_neg, out_neg, par_bad;
  logic [SEQ_W-1:0]  in_seq_w, out_seq_w, gap;
  kind_t             ev_kind;
  status_t           ev_status;
  logic              ev_pay;
  logic [SEQ_W-1:0]  ev_seq;
  logic [AW-1:0]     ev_park_addr;

  always_comb begin
    in_neg    = rin_r[RAW_W-1];
    out_neg   = rout_r[RAW_W-1];
    in_seq_w  = rin_r[SEQ_W:1];
    out_seq_w = rout_r[SEQ_W:1];
    par_bad   = (rout_r[0] == admin_r) || (rin_r[0] != admin_r);
    gap       = out_seq_w - expected_r;
    ev_park_addr = phys(head_r, CW'(gap[AW-1:0]));
    ev_kind   = K_REPORT;
    ev_pay    = 1'b1;
    ev_seq    = '0;
    priority if (!ok_r) begin
      ev_status = ST_NO_MESSAGE;
      ev_pay    = 1'b0;
    end else if (in_neg && out_neg) begin
      ev_status = ST_DELIVERED;
    end else if (in_neg || out_neg) begin
      ev_status = ST_MIXED;
    end else if (par_bad) begin
      ev_status = ST_BAD_PARITY;
    end else if (in_seq_w > local_r) begin
      ev_status = ST_AHEAD_LOCAL;
    end else if (out_seq_w < expected_r) begin
      ev_status = ST_STALE;
      ev_seq    = out_seq_w;
    end else if (out_seq_w != expected_r) begin
      ev_seq = out_seq_w;
      if (gap >= SEQ_W'(WINDOW)) begin
        ev_status = ST_OVERFLOW;
      end else begin
        ev_kind   = K_PARK;
        ev_status = resend_r ? ST_RESEND_PARKED : ST_PARKED;
        ev_pay    = !resend_r;
      end
    end else begin
      ev_kind   = K_INORDER;
      ev_status = ST_DELIVERED;
    end
  end

  // ---------------- sequencer control ----------------
  logic          can_load;
  logic          out_load;
  logic          drain_last;
  logic [CW-1:0] d_inc;

  assign can_load   = !out_valid_r || !out_stall;
  assign out_load   = can_load &&
                      (state_r == S_OUT || state_r == S_HEAD || state_r == S_DRAIN);
  assign d_inc      = d_r + CW'(1);
  assign drain_last = (d_inc == n_r);
  assign in_stall   = (state_r != S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys(head_r, d_r);
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = phys(head_r, d_inc);
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = d_r[AW-1:0];
      end
      S_EVAL: begin
        if (ev_kind == K_PARK) begin
          ram_re    = 1'b1;
          ram_raddr = ev_park_addr;
        end else if (ev_kind == K_INORDER) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_r, CW'(1));
        end
      end
      S_PARK: begin
        // a slot already taken keeps its first entry
        ram_we    = !rd.valid;
        ram_waddr = park_addr_r;
        ram_wdata = '{valid: 1'b1, payload: !resend_r, tag: tag_in_r};
      end
      S_SCAN: begin
        ram_re = rd.valid && (d_inc < CW'(WINDOW));
      end
      S_HEAD: begin
        ram_re    = can_load && (n_r != CW'(1));
        ram_raddr = phys(head_r, CW'(1));
      end
      S_DRAIN: begin
        ram_we = can_load;
        ram_re = can_load && !drain_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      admin_r     <= 1'b0;
      expected_r  <= '0;
      head_r      <= '0;
      d_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        admin_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          d_r <= d_inc;
          if (d_r == CW'(WINDOW - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            rin_r    <= in_raw_in_seq;
            rout_r   <= in_raw_out_seq;
            tag_in_r <= in_message_tag;
            ok_r     <= in_message_ok;
            resend_r <= in_is_resend_request;
            local_r  <= in_local_out_seq;
            state_r  <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_status_r <= ev_status;
          res_tag_r    <= tag_in_r;
          res_pay_r    <= ev_pay;
          res_seq_r    <= ev_seq;
          park_addr_r  <= ev_park_addr;
          d_r          <= CW'(1);
          unique case (ev_kind)
            K_PARK:    state_r <= S_PARK;
            K_INORDER: state_r <= S_SCAN;
            default:   state_r <= S_OUT;
          endcase
        end
        S_PARK: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (can_load) begin
            out_status_r <= res_status_r;
            out_tag_r    <= res_tag_r;
            out_pay_r    <= res_pay_r;
            out_seq_r    <= res_seq_r;
            out_exp_r    <= expected_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_SCAN: begin
          // rd holds slot d_r; stop at the first empty slot or the window end
          if (rd.valid && (d_inc < CW'(WINDOW))) begin
            d_r <= d_inc;
          end else begin
            n_r         <= rd.valid ? CW'(WINDOW) : d_r;
            exp_after_r <= expected_r + SEQ_W'(rd.valid ? CW'(WINDOW) : d_r);
            state_r     <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (can_load) begin
            out_status_r <= ST_DELIVERED;
            out_tag_r    <= tag_in_r;
            out_pay_r    <= 1'b1;
            out_seq_r    <= expected_r;
            out_exp_r    <= exp_after_r;
            out_last_r   <= (n_r == CW'(1));
            d_r          <= CW'(1);
            if (n_r == CW'(1)) begin
              expected_r <= exp_after_r;
              head_r     <= phys(head_r, n_r);
              state_r    <= S_IDLE;
            end else begin
              state_r    <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (can_load) begin
            out_status_r <= ST_DELIVERED;
            out_tag_r    <= rd.tag;
            out_pay_r    <= rd.payload;
            out_seq_r    <= expected_r + SEQ_W'(d_r);
            out_exp_r    <= exp_after_r;
            out_last_r   <= drain_last;
            d_r          <= d_inc;
            if (drain_last) begin
              expected_r <= exp_after_r;
              head_r     <= phys(head_r, n_r);
              state_r    <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_tag            = out_tag_r;
  assign out_has_payload    = out_pay_r;
  assign out_seq            = out_seq_r;
  assign out_expected_after = out_exp_r;
  assign out_last           = out_last_r;

  // ---------------- assertions ----------------
  a_drain_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> rd.valid)
    else $error("drain reached an empty slot");

  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRAIN |-> (d_r < n_r) && (d_r != '0))
    else $error("drain index out of run");

  a_park_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_PARK) |-> !rd.valid)
    else $error("park overwrote an occupied slot");

  a_expected_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && can_load && drain_last) |=> expected_r == $past(exp_after_r))
    else $error("expected number not advanced after run");

  a_no_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_CLR) |=> !$rose(out_valid_r))
    else $error("result produced without an item in flight");

endmodule

`default_nettype wire

FILE: sv/srb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module srb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
